[rtl/slt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the sorted list table unit.
// No dependencies; used by every module of the block but slt_ram.
package slt_pkg;

    // Fixed widths of the item fields
    localparam int OP_W      = 3;
    localparam int IN_VAL_W  = 32;
    localparam int POS_W     = 6;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 7;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [STAT_W-1:0] t_status;

    // Operation codes
    localparam t_op OP_INSERT  = 3'd0;
    localparam t_op OP_APPEND  = 3'd1;
    localparam t_op OP_REMOVE  = 3'd2;
    localparam t_op OP_REVERSE = 3'd3;
    localparam t_op OP_CHECK   = 3'd4;

    // Status codes
    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_FULL = 2'd1;
    localparam t_status ST_POS  = 2'd2;

    // Control from the sequencer to the order tracker
    typedef struct packed {
        logic clear;  // restart the order scan
        logic vld;    // read data carries the next entry of the scan
        logic swap;   // table was reversed: exchange the flags
    } t_ord_ctl;

endpackage

[rtl/sorted_list_table_unit.sv]
`timescale 1ns / 1ps
// Top level of the sorted list table: sequencer, entry store and order tracker.
// Depends on slt_pkg, slt_ram, slt_order and slt_seq.
//
//   channel   | handshake            | payload
//   ----------+----------------------+------------------------------------------
//   command   | start, busy          | i_operation, i_new_value, i_position
//   result    | o_valid (one cycle)  | o_status, o_entry_count, o_is_ascending,
//             |                      | o_is_descending, o_removed_value
//
// An item is taken when start is high and busy is low. Refused items, check,
// unused codes and reverse of a table under two entries answer in the next cycle.
// Operations walk the single-read-port entry store, and each insert, append
// or remove ends in a full read sweep that rebuilds the order flags. Reset is
// synchronous, active low, and clears control, the count and the order flags;
// the store needs no clearing.
// The result cannot be held off: o_valid is high for exactly one cycle.
module sorted_list_table_unit #(
    parameter int NUM_ENTRIES = 64,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  slt_pkg::t_op                        i_operation,
    input  logic signed [slt_pkg::IN_VAL_W-1:0] i_new_value,
    input  logic [slt_pkg::POS_W-1:0]           i_position,
    output logic                                o_valid,
    output slt_pkg::t_status                    o_status,
    output logic [slt_pkg::CNT_OUT_W-1:0]       o_entry_count,
    output logic                                o_is_ascending,
    output logic                                o_is_descending,
    output logic signed [slt_pkg::IN_VAL_W-1:0] o_removed_value
);

    localparam int AW   = $clog2(NUM_ENTRIES);
    localparam int CW   = $clog2(NUM_ENTRIES + 1);
    localparam int CNTX = (CW > slt_pkg::CNT_OUT_W) ? CW : slt_pkg::CNT_OUT_W;

    logic [VALUE_BITS-1:0] w_val;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [VALUE_BITS-1:0] w_rd_data;
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [VALUE_BITS-1:0] w_wr_data;
    slt_pkg::t_ord_ctl     w_ord;
    logic [CW-1:0]         w_count;
    logic [CNTX-1:0]       w_count_x;
    logic [VALUE_BITS-1:0] w_rm;

    // Sign extend the incoming value to the store width, or keep its low bits
    assign w_val = VALUE_BITS'(i_new_value);

    slt_seq #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_busy    (busy),
        .i_op      (i_operation),
        .i_val     (w_val),
        .i_pos     (i_position),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_ord     (w_ord),
        .o_done    (o_valid),
        .o_status  (o_status),
        .o_count   (w_count),
        .o_removed (w_rm)
    );

    slt_ram #(
        .DEPTH (NUM_ENTRIES),
        .WIDTH (VALUE_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    // Flags hold between scans; reverse swaps them, a fresh scan rebuilds them
    slt_order #(
        .VALUE_BITS (VALUE_BITS)
    ) u_order (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ord),
        .i_data  (w_rd_data),
        .o_asc   (o_is_ascending),
        .o_desc  (o_is_descending)
    );

    // Report the count in the fixed field width; drop bits above it
    assign w_count_x     = CNTX'(w_count);
    assign o_entry_count = w_count_x[slt_pkg::CNT_OUT_W-1:0];

    // Removed entry is reported zero extended from the store width
    assign o_removed_value = $signed(slt_pkg::IN_VAL_W'(w_rm));

    // Reads always run ahead of writes: never the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_rd_en && w_wr_en && (w_rd_addr == w_wr_addr)))
        else $error("read and write hit the same entry");

    // An accepted item is either worked on or answered at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted item neither in progress nor answered");

    // The count never exceeds the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(NUM_ENTRIES))
        else $error("entry count beyond table size");

    // A refused item reports no removed value
    a_refused_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != slt_pkg::ST_OK)) |-> (o_removed_value == '0))
        else $error("refused item carries a removed value");

endmodule

[rtl/slt_ram.sv]
`timescale 1ns / 1ps
// Entry store: one write port, one read port, read data registered.
// No dependencies.
module slt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/slt_order.sv]
`timescale 1ns / 1ps
// Order tracker: builds the ascending and descending flags from a stream of entries.
// Depends on slt_pkg.
module slt_order #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  slt_pkg::t_ord_ctl     i_ctl,
    input  logic [VALUE_BITS-1:0] i_data,
    output logic                  o_asc,
    output logic                  o_desc
);

    logic                  r_asc, n_asc;
    logic                  r_desc, n_desc;
    logic                  r_have, n_have;
    logic [VALUE_BITS-1:0] r_prev, n_prev;

    always_comb begin
        n_asc  = r_asc;
        n_desc = r_desc;
        n_have = r_have;
        n_prev = r_prev;
        if (i_ctl.clear) begin
            n_asc  = 1'b1;
            n_desc = 1'b1;
            n_have = 1'b0;
        end else if (i_ctl.swap) begin
            n_asc  = r_desc;
            n_desc = r_asc;
        end else if (i_ctl.vld) begin
            if (r_have && ($signed(i_data) < $signed(r_prev))) begin
                n_asc = 1'b0;
            end
            if (r_have && ($signed(i_data) > $signed(r_prev))) begin
                n_desc = 1'b0;
            end
            n_prev = i_data;
            n_have = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asc  <= 1'b1;
            r_desc <= 1'b1;
            r_have <= 1'b0;
        end else begin
            r_asc  <= n_asc;
            r_desc <= n_desc;
            r_have <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
    end

    assign o_asc  = r_asc;
    assign o_desc = r_desc;

endmodule

[rtl/slt_seq.sv]
`timescale 1ns / 1ps
// Sequencer: walks the entry store for insert, append, remove, reverse and the order scan.
// Depends on slt_pkg; drives slt_ram and slt_order from the top level.
module slt_seq #(
    parameter int NUM_ENTRIES = 64,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  slt_pkg::t_op                         i_op,
    input  logic [VALUE_BITS-1:0]                i_val,
    input  logic [slt_pkg::POS_W-1:0]            i_pos,
    output logic                                 o_rd_en,
    output logic [$clog2(NUM_ENTRIES)-1:0]       o_rd_addr,
    input  logic [VALUE_BITS-1:0]                i_rd_data,
    output logic                                 o_wr_en,
    output logic [$clog2(NUM_ENTRIES)-1:0]       o_wr_addr,
    output logic [VALUE_BITS-1:0]                o_wr_data,
    output slt_pkg::t_ord_ctl                    o_ord,
    output logic                                 o_done,
    output slt_pkg::t_status                     o_status,
    output logic [$clog2(NUM_ENTRIES+1)-1:0]     o_count,
    output logic [VALUE_BITS-1:0]                o_removed
);

    localparam int AW = $clog2(NUM_ENTRIES);
    localparam int CW = $clog2(NUM_ENTRIES + 1);
    localparam int PW = (CW > slt_pkg::POS_W) ? CW : slt_pkg::POS_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PASS  = 4'd1;
    localparam logic [3:0] S_FINAL = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_RA    = 4'd4;
    localparam logic [3:0] S_RB    = 4'd5;
    localparam logic [3:0] S_RC    = 4'd6;
    localparam logic [3:0] S_RD    = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_idx, n_idx;
    logic                  r_dv, n_dv;
    logic [AW-1:0]         r_didx, n_didx;
    logic                  r_ins, n_ins;
    slt_pkg::t_op          r_op, n_op;
    slt_pkg::t_status      r_status, n_status;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [VALUE_BITS-1:0] r_carry, n_carry;
    logic [VALUE_BITS-1:0] r_dlo, n_dlo;
    logic [VALUE_BITS-1:0] r_rm, n_rm;
    logic [AW-1:0]         r_pos, n_pos;
    logic [AW-1:0]         r_lo, n_lo;
    logic [AW-1:0]         r_hi, n_hi;

    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic          issue;
    logic          full;

    assign pos_ext = PW'(i_pos);
    assign cnt_ext = PW'(r_count);
    assign issue   = (r_idx < r_count);
    assign full    = (r_count == CW'(NUM_ENTRIES));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_dv      = r_dv;
        n_didx    = r_didx;
        n_ins     = r_ins;
        n_op      = r_op;
        n_status  = r_status;
        n_val     = r_val;
        n_carry   = r_carry;
        n_dlo     = r_dlo;
        n_rm      = r_rm;
        n_pos     = r_pos;
        n_lo      = r_lo;
        n_hi      = r_hi;
        o_rd_en   = 1'b0;
        o_rd_addr = r_idx[AW-1:0];
        o_wr_en   = 1'b0;
        o_wr_addr = r_didx;
        o_wr_data = r_val;
        o_ord     = '0;

        case (r_state)
            S_IDLE, S_DONE: begin
                n_state = S_IDLE;
                if (i_start) begin
                    n_op     = i_op;
                    n_val    = i_val;
                    n_status = slt_pkg::ST_OK;
                    n_rm     = '0;
                    n_ins    = 1'b0;
                    n_dv     = 1'b0;
                    n_state  = S_DONE;
                    case (i_op)
                        slt_pkg::OP_INSERT, slt_pkg::OP_APPEND: begin
                            if (full) begin
                                n_status = slt_pkg::ST_FULL;
                            end else begin
                                n_idx   = (i_op == slt_pkg::OP_INSERT) ? '0 : r_count;
                                n_state = S_PASS;
                            end
                        end
                        slt_pkg::OP_REMOVE: begin
                            if (pos_ext >= cnt_ext) begin
                                n_status = slt_pkg::ST_POS;
                            end else begin
                                n_idx   = pos_ext[CW-1:0];
                                n_pos   = pos_ext[AW-1:0];
                                n_state = S_PASS;
                            end
                        end
                        slt_pkg::OP_REVERSE: begin
                            if (r_count > CW'(1)) begin
                                n_lo    = '0;
                                n_hi    = AW'(r_count - CW'(1));
                                n_state = S_RA;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_PASS: begin
                if (issue) begin
                    o_rd_en = 1'b1;
                    n_idx   = r_idx + CW'(1);
                    n_dv    = 1'b1;
                    n_didx  = r_idx[AW-1:0];
                end else begin
                    n_dv    = 1'b0;
                    n_state = S_FINAL;
                end
                if (r_dv) begin
                    if (r_op == slt_pkg::OP_REMOVE) begin
                        if (r_didx == r_pos) begin
                            n_rm = i_rd_data;
                        end else begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = r_didx - AW'(1);
                            o_wr_data = i_rd_data;
                        end
                    end else if (r_ins) begin
                        o_wr_en   = 1'b1;
                        o_wr_data = r_carry;
                        n_carry   = i_rd_data;
                    end else if ($signed(i_rd_data) > $signed(r_val)) begin
                        o_wr_en   = 1'b1;
                        o_wr_data = r_val;
                        n_carry   = i_rd_data;
                        n_ins     = 1'b1;
                    end
                end
            end
            S_FINAL: begin
                if (r_op == slt_pkg::OP_REMOVE) begin
                    n_count = r_count - CW'(1);
                end else begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_count[AW-1:0];
                    o_wr_data = r_ins ? r_carry : r_val;
                    n_count   = r_count + CW'(1);
                end
                o_ord.clear = 1'b1;
                n_idx       = '0;
                n_dv        = 1'b0;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                o_ord.vld = r_dv;
                if (issue) begin
                    o_rd_en = 1'b1;
                    n_idx   = r_idx + CW'(1);
                    n_dv    = 1'b1;
                end else begin
                    n_dv    = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_RA: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_lo;
                n_state   = S_RB;
            end
            S_RB: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_hi;
                n_dlo     = i_rd_data;
                n_state   = S_RC;
            end
            S_RC: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_lo;
                o_wr_data = i_rd_data;
                n_state   = S_RD;
            end
            S_RD: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_hi;
                o_wr_data = r_dlo;
                n_lo      = r_lo + AW'(1);
                n_hi      = r_hi - AW'(1);
                if (n_hi > n_lo) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = n_lo;
                    n_state   = S_RB;
                end else begin
                    o_ord.swap = 1'b1;
                    n_state    = S_DONE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_dv    <= 1'b0;
            r_ins   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_dv    <= n_dv;
            r_ins   <= n_ins;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_didx   <= n_didx;
        r_op     <= n_op;
        r_status <= n_status;
        r_val    <= n_val;
        r_carry  <= n_carry;
        r_dlo    <= n_dlo;
        r_rm     <= n_rm;
        r_pos    <= n_pos;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
    end

    assign o_busy    = (r_state != S_IDLE) && (r_state != S_DONE);
    assign o_done    = (r_state == S_DONE);
    assign o_status  = r_status;
    assign o_count   = r_count;
    assign o_removed = r_rm;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for sorted_list_table_unit: a table of directed items, then random bursts.
// Depends on slt_pkg and the RTL of sorted_list_table_unit; needs no other file.
module tb;

    localparam int NUM_ENTRIES    = 64;
    localparam int VALUE_BITS     = 32;
    localparam int DIRECTED_ROWS  = 25;
    localparam int RANDOM_ITEMS   = 825;
    localparam int DRAIN_CYCLES   = 3 * NUM_ENTRIES + 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    // Codes the block does not decode: they must leave the table untouched
    localparam slt_pkg::t_op OP_RSVD5 = 3'd5;
    localparam slt_pkg::t_op OP_RSVD6 = 3'd6;
    localparam slt_pkg::t_op OP_RSVD7 = 3'd7;

    typedef enum int {BURST_GROW, BURST_SHRINK, BURST_SORTED, BURST_NOISE} t_burst_kind;

    typedef struct packed {
        slt_pkg::t_status                     status;
        logic [slt_pkg::CNT_OUT_W-1:0]        entry_count;
        logic                                 ascending;
        logic                                 descending;
        logic signed [slt_pkg::IN_VAL_W-1:0]  removed;
    } t_table_result;

    // Expected result typed in by hand, or left to the table model
    typedef struct packed {
        logic          known;
        t_table_result res;
    } t_typed_result;

    typedef struct packed {
        slt_pkg::t_op  op;
        logic [31:0]   val;
        logic [5:0]    pos;
        t_typed_result typed;
    } t_plan_row;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 start = 1'b0;
    logic                                 busy;
    slt_pkg::t_op                         i_operation = slt_pkg::OP_CHECK;
    logic signed [slt_pkg::IN_VAL_W-1:0]  i_new_value = '0;
    logic [slt_pkg::POS_W-1:0]            i_position = '0;
    logic                                 o_valid;
    slt_pkg::t_status                     o_status;
    logic [slt_pkg::CNT_OUT_W-1:0]        o_entry_count;
    logic                                 o_is_ascending;
    logic                                 o_is_descending;
    logic signed [slt_pkg::IN_VAL_W-1:0]  o_removed_value;

    // Model of the table: values below tbl_len are live
    logic signed [VALUE_BITS-1:0]  tbl_vals [NUM_ENTRIES];
    int                            tbl_len = 0;

    t_table_result                 awaited_results [$];
    t_typed_result                 typed_q [$];
    t_plan_row                     plan [DIRECTED_ROWS];
    int                            fault_count = 0;
    int                            idle_cycles = 0;
    int                            sender_idle_pct = 0;

    sorted_list_table_unit #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .VALUE_BITS  (VALUE_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_new_value     (i_new_value),
        .i_position      (i_position),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count),
        .o_is_ascending  (o_is_ascending),
        .o_is_descending (o_is_descending),
        .o_removed_value (o_removed_value)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Append to the tail of the outstanding queues
    function automatic void queue_typed(input t_typed_result t);
        typed_q = {typed_q, t};
    endfunction

    function automatic void queue_awaited(input t_table_result r);
        awaited_results = {awaited_results, r};
    endfunction

    // Apply one operation to the model table and return the result it must give
    function automatic t_table_result apply_table_op(input slt_pkg::t_op op,
                                                     input logic signed [31:0] val,
                                                     input logic [5:0] pos);
        t_table_result r;
        int at;
        int lo;
        int hi;
        int k;
        logic signed [VALUE_BITS-1:0] swap_val;
        r = '0;
        r.status = slt_pkg::ST_OK;
        case (op)
            slt_pkg::OP_INSERT, slt_pkg::OP_APPEND: begin
                if (tbl_len >= NUM_ENTRIES) begin
                    r.status = slt_pkg::ST_FULL;
                end else begin
                    at = tbl_len;
                    // walk down so that the lowest strictly larger entry wins
                    if (op == slt_pkg::OP_INSERT) begin
                        for (k = tbl_len - 1; k >= 0; k--)
                            if (tbl_vals[k] > val) at = k;
                    end
                    for (k = tbl_len; k > at; k--) tbl_vals[k] = tbl_vals[k - 1];
                    tbl_vals[at] = val;
                    tbl_len++;
                end
            end
            slt_pkg::OP_REMOVE: begin
                if (int'(pos) >= tbl_len) begin
                    r.status = slt_pkg::ST_POS;
                end else begin
                    r.removed = tbl_vals[pos];
                    for (k = int'(pos); k + 1 < tbl_len; k++) tbl_vals[k] = tbl_vals[k + 1];
                    tbl_len--;
                end
            end
            slt_pkg::OP_REVERSE: begin
                lo = 0;
                hi = tbl_len - 1;
                while (lo < hi) begin
                    swap_val     = tbl_vals[lo];
                    tbl_vals[lo] = tbl_vals[hi];
                    tbl_vals[hi] = swap_val;
                    lo++;
                    hi--;
                end
            end
            default: ;
        endcase
        // order flags describe the table after every operation
        r.ascending  = 1'b1;
        r.descending = 1'b1;
        for (k = 1; k < tbl_len; k++) begin
            if (tbl_vals[k] < tbl_vals[k - 1]) r.ascending = 1'b0;
            if (tbl_vals[k] > tbl_vals[k - 1]) r.descending = 1'b0;
        end
        r.entry_count = tbl_len[slt_pkg::CNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic t_plan_row cmd_row(input slt_pkg::t_op op, input logic [31:0] v,
                                          input logic [5:0] p);
        t_plan_row row;
        row = '0;
        row.op  = op;
        row.val = v;
        row.pos = p;
        return row;
    endfunction

    function automatic t_plan_row checked_row(input slt_pkg::t_op op, input logic [31:0] v,
                                              input logic [5:0] p,
                                              input slt_pkg::t_status st,
                                              input int cnt, input bit asc, input bit desc,
                                              input logic [31:0] rem);
        t_plan_row row;
        row = cmd_row(op, v, p);
        row.typed.known              = 1'b1;
        row.typed.res.status         = st;
        row.typed.res.entry_count    = cnt[slt_pkg::CNT_OUT_W-1:0];
        row.typed.res.ascending      = asc;
        row.typed.res.descending     = desc;
        row.typed.res.removed        = rem;
        return row;
    endfunction

    // Mix of wide random values, a narrow band that breeds equal entries, and extremes
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(7))
            3, 4:    return int'($urandom_range(8)) - 4;
            5:       return 32'sh8000_0000;
            6:       return 32'sh7FFF_FFFF;
            7:       return $urandom_range(1) ? 32'sd0 : -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic note_fault(input string what, input t_table_result want,
                              input t_table_result got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("%0t %s: status %0d/%0d count %0d/%0d asc %b/%b desc %b/%b removed %0d/%0d",
                     $realtime, what, want.status, got.status, want.entry_count,
                     got.entry_count, want.ascending, got.ascending, want.descending,
                     got.descending, want.removed, got.removed);
    endtask

    // Hold the item on the bus until the block takes it; idle the sender at random first
    task automatic issue_item(input slt_pkg::t_op op, input logic signed [31:0] val,
                              input logic [5:0] pos, input t_typed_result typed);
        int gap;
        queue_typed(typed);
        if ($urandom_range(99) < sender_idle_pct) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(160, 5) : $urandom_range(4, 1);
            repeat (gap) begin
                // drop start and scramble the fields: the block must ignore them
                start       <= 1'b0;
                i_operation <= slt_pkg::t_op'($urandom_range(7));
                i_new_value <= $urandom;
                i_position  <= slt_pkg::POS_W'($urandom);
                @(posedge i_clk);
            end
        end
        start       <= 1'b1;
        i_operation <= op;
        i_new_value <= val;
        i_position  <= pos;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    // Monitor: take results first so a result never meets its own item's expectation early
    always @(posedge i_clk) begin
        t_table_result got;
        t_table_result want;
        t_table_result predicted;
        t_typed_result typed;
        bit            taken;
        if (i_rst_n) begin
            taken = (start === 1'b1) && (busy === 1'b0);
            if (o_valid === 1'b1) begin
                got.status      = o_status;
                got.entry_count = o_entry_count;
                got.ascending   = o_is_ascending;
                got.descending  = o_is_descending;
                got.removed     = o_removed_value;
                if (awaited_results.size() == 0) begin
                    note_fault("result with nothing outstanding", '0, got);
                end else begin
                    want = awaited_results.pop_front();
                    if (want.status !== got.status || want.entry_count !== got.entry_count ||
                        want.ascending !== got.ascending || want.descending !== got.descending ||
                        want.removed !== got.removed)
                        note_fault("result mismatch (expected/actual)", want, got);
                end
            end
            if (taken) begin
                predicted = apply_table_op(i_operation, i_new_value, i_position);
                typed = (typed_q.size() != 0) ? typed_q.pop_front() : '0;
                queue_awaited(typed.known ? typed.res : predicted);
            end
            // advance the watchdog only while neither side moves
            if (taken || o_valid === 1'b1) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int                 sent;
        int                 burst;
        int                 k;
        int                 ph;
        t_burst_kind        mode;
        slt_pkg::t_op       op;
        logic signed [31:0] v;
        logic [5:0]         p;

        // Empty table first, then the extremes of the value range and their order flags
        plan[0]  = checked_row(slt_pkg::OP_CHECK,   32'h0, 6'd0,  slt_pkg::ST_OK,
                               0, 1, 1, 32'h0);
        plan[1]  = checked_row(slt_pkg::OP_REMOVE,  32'h0, 6'd0,  slt_pkg::ST_POS,
                               0, 1, 1, 32'h0);
        plan[2]  = checked_row(slt_pkg::OP_REMOVE,  32'h0, 6'd63, slt_pkg::ST_POS,
                               0, 1, 1, 32'h0);
        plan[3]  = checked_row(slt_pkg::OP_REVERSE, 32'h0, 6'd0,  slt_pkg::ST_OK,
                               0, 1, 1, 32'h0);
        plan[4]  = checked_row(slt_pkg::OP_INSERT,  32'h7FFF_FFFF, 6'd0, slt_pkg::ST_OK,
                               1, 1, 1, 32'h0);
        plan[5]  = checked_row(slt_pkg::OP_REVERSE, 32'h0, 6'd0,  slt_pkg::ST_OK,
                               1, 1, 1, 32'h0);
        plan[6]  = checked_row(slt_pkg::OP_INSERT,  32'h8000_0000, 6'd0, slt_pkg::ST_OK,
                               2, 1, 0, 32'h0);
        plan[7]  = checked_row(slt_pkg::OP_REMOVE,  32'h0, 6'd1,  slt_pkg::ST_OK,
                               1, 1, 1, 32'h7FFF_FFFF);
        plan[8]  = checked_row(slt_pkg::OP_INSERT,  32'h7FFF_FFFF, 6'd0, slt_pkg::ST_OK,
                               2, 1, 0, 32'h0);
        plan[9]  = checked_row(slt_pkg::OP_REVERSE, 32'h0, 6'd0,  slt_pkg::ST_OK,
                               2, 0, 1, 32'h0);
        // Unsorted table: insert lands before the first strictly larger entry
        plan[10] = cmd_row(slt_pkg::OP_APPEND,  32'h0, 6'd0);
        plan[11] = cmd_row(slt_pkg::OP_INSERT,  32'h0, 6'd0);
        plan[12] = cmd_row(slt_pkg::OP_INSERT,  32'hFFFF_FFFF, 6'd0);
        plan[13] = cmd_row(slt_pkg::OP_APPEND,  32'h0, 6'd0);
        plan[14] = cmd_row(slt_pkg::OP_CHECK,   32'h0, 6'd0);
        plan[15] = cmd_row(slt_pkg::OP_REVERSE, 32'h0, 6'd0);
        // Positions beyond and at the count are refused; then take the ends off
        plan[16] = cmd_row(slt_pkg::OP_REMOVE,  32'h0, 6'd63);
        plan[17] = cmd_row(slt_pkg::OP_REMOVE,  32'h0, 6'd6);
        plan[18] = cmd_row(slt_pkg::OP_REMOVE,  32'h0, 6'd5);
        plan[19] = cmd_row(slt_pkg::OP_REMOVE,  32'h0, 6'd0);
        plan[20] = cmd_row(OP_RSVD5,            32'hFFFF_FFFF, 6'd63);
        plan[21] = cmd_row(OP_RSVD6,            32'hFFFF_FFFF, 6'd63);
        plan[22] = cmd_row(OP_RSVD7,            32'hFFFF_FFFF, 6'd63);
        plan[23] = cmd_row(slt_pkg::OP_INSERT,  32'h5555_5555, 6'd42);
        plan[24] = cmd_row(slt_pkg::OP_APPEND,  32'hAAAA_AAAA, 6'd21);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 34;
        for (k = 0; k < DIRECTED_ROWS; k++)
            issue_item(plan[k].op, $signed(plan[k].val), plan[k].pos, plan[k].typed);

        // Random bursts: grow to full, shrink to empty, keep sorted, or plain noise.
        // Three idling phases: sender idles a third, then over half, then never.
        for (ph = 0; ph < 3; ph++) begin
            sender_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 56 : 0;
            sent = 0;
            while (sent < RANDOM_ITEMS / 3) begin
                mode  = t_burst_kind'($urandom_range(3));
                burst = $urandom_range(80, 10);
                for (k = 0; k < burst && sent < RANDOM_ITEMS / 3; k++) begin
                    v = pick_value();
                    p = slt_pkg::POS_W'($urandom);
                    case (mode)
                        BURST_GROW: begin
                            if ($urandom_range(9) == 0) begin
                                op = slt_pkg::t_op'($urandom_range(4));
                            end else begin
                                op = $urandom_range(1) ? slt_pkg::OP_INSERT
                                                       : slt_pkg::OP_APPEND;
                            end
                        end
                        BURST_SHRINK: begin
                            op = ($urandom_range(4) == 0) ? slt_pkg::t_op'($urandom_range(4))
                                                          : slt_pkg::OP_REMOVE;
                            // aim mostly at live positions, now and then just past the end
                            if ($urandom_range(7) != 0)
                                p = slt_pkg::POS_W'($urandom_range(tbl_len));
                        end
                        BURST_SORTED: begin
                            case ($urandom_range(19))
                                0:       op = slt_pkg::OP_REVERSE;
                                1, 2:    op = slt_pkg::OP_CHECK;
                                default: op = slt_pkg::OP_INSERT;
                            endcase
                            if ($urandom_range(1)) v = int'($urandom_range(8)) - 4;
                        end
                        default: op = slt_pkg::t_op'($urandom_range(7));
                    endcase
                    issue_item(op, v, p, '0);
                    sent++;
                end
            end
        end

        // Release start, wait for the last result, then hold for stray strobes
        start <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/slt_pkg.sv
rtl/slt_ram.sv
rtl/slt_order.sv
rtl/slt_seq.sv
rtl/sorted_list_table_unit.sv
tb/sv/tb.sv
